// ===== src/wstq_pkg.sv =====
package wstq_pkg;

  localparam int WORKERS_DEF      = 8;
  localparam int LOCAL_DEPTH_DEF  = 256;
  localparam int GLOBAL_DEPTH_DEF = 1024;
  localparam int TASK_BITS_DEF    = 16;

  localparam int KIND_W   = 2;
  localparam int WORKER_W = 3;
  localparam int TASK_W   = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 12;
  localparam int ACTIVE_W = 4;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  typedef enum logic [KIND_W-1:0] {
    KIND_EXT   = 2'd0,
    KIND_LOCAL = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOCAL  = 3'd0,
    ST_GLOBAL = 3'd1,
    ST_OWN    = 3'd2,
    ST_SHARED = 3'd3,
    ST_STOLEN = 3'd4,
    ST_NONE   = 3'd5,
    ST_REJECT = 3'd6,
    ST_SPARE  = 3'd7
  } status_t;

  // operation decided by the front part
  typedef enum logic [2:0] {
    OP_PUSH_LOCAL  = 3'd0,
    OP_PUSH_GLOBAL = 3'd1,
    OP_POP_OWN     = 3'd2,
    OP_POP_GLOBAL  = 3'd3,
    OP_STEAL       = 3'd4,
    OP_NOTHING     = 3'd5
  } op_t;

endpackage

// ===== src/wstq_if.sv =====
interface wstq_req_if;
  import wstq_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [WORKER_W-1:0] worker;
  logic [TASK_W-1:0]   task_req;
  modport source (output valid, kind, worker, task_req, input ready);
  modport sink (input valid, kind, worker, task_req, output ready);
endinterface

interface wstq_rsp_if;
  import wstq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TASK_W-1:0]   task_out;
  logic [WORKER_W-1:0] victim;
  logic [COUNT_W-1:0]  queued_total;
  modport source (output valid, status, task_out, victim, queued_total, input ready);
  modport sink (input valid, status, task_out, victim, queued_total, output ready);
endinterface

// ===== src/wstq_ram.sv =====
module wstq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/wstq_front.sv =====
module wstq_front
  import wstq_pkg::*;
#(
  parameter int WORKERS      = WORKERS_DEF,
  parameter int LOCAL_DEPTH  = LOCAL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = GLOBAL_DEPTH_DEF,
  parameter int TASK_BITS    = TASK_BITS_DEF,
  localparam int WI_W = $clog2(WORKERS),
  localparam int LP_W = $clog2(LOCAL_DEPTH) + 1,
  localparam int GP_W = $clog2(GLOBAL_DEPTH) + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [ACTIVE_W-1:0] active_workers,
  wstq_req_if.sink            req,
  // classified op towards the queue
  output logic                op_valid,
  input  logic                op_ready,
  output op_t                 op_code,
  output logic [WI_W-1:0]     op_worker,
  output logic [TASK_BITS-1:0] op_task,
  // occupancy seen from the back part
  input  logic [LP_W-1:0]     dq_size [WORKERS],
  input  logic [GP_W-1:0]     sh_size,
  input  logic                busy
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } fstate_t;

  fstate_t state, state_next;
  logic [KIND_W-1:0]    kind_q;
  logic [WORKER_W-1:0]  wrk_q;
  logic [TASK_BITS-1:0] task_q;
  logic [WI_W:0]        scan_i;
  logic [LP_W-1:0]      best;
  logic [WI_W-1:0]      sel;
  logic                 found;
  op_t                  op_q;
  logic [WI_W-1:0]      opw_q;
  logic [ACTIVE_W:0]    n_eff;
  logic                 w_ok;
  logic [WI_W-1:0]      w_idx;

  // effective worker count clamped to 1..WORKERS
  always_comb begin
    if (active_workers == '0) begin
      n_eff = (ACTIVE_W+1)'(1);
    end else if (int'(active_workers) > WORKERS) begin
      n_eff = (ACTIVE_W+1)'(WORKERS);
    end else begin
      n_eff = {1'b0, active_workers};
    end
  end

  assign w_ok  = ({{(ACTIVE_W+1-WORKER_W){1'b0}}, wrk_q}) < n_eff;
  assign w_idx = WI_W'(wrk_q);
  // the back part must have settled before occupancy is sampled
  assign req.ready = (state == S_IDLE) && !busy;
  assign op_valid  = (state == S_EMIT);
  assign op_code   = op_q;
  assign op_worker = opw_q;
  assign op_task   = task_q;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req.valid && req.ready) state_next = S_SCAN;
      S_SCAN: begin
        if (kind_q != KIND_FETCH || !w_ok || dq_size[w_idx] != '0 || sh_size != '0 ||
            int'(scan_i) >= int'(n_eff) - 1 || int'(scan_i) >= WORKERS - 1) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: if (op_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request capture and classification, victim scan one worker a cycle
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid && req.ready) begin
      kind_q <= req.kind;
      wrk_q  <= req.worker;
      task_q <= TASK_BITS'(req.task_req);
      scan_i <= '0;
      best   <= '0;
      found  <= 1'b0;
      sel    <= '0;
    end else if (state == S_SCAN) begin
      logic stealable;
      stealable = (scan_i != (WI_W+1)'(wrk_q)) &&
                  (dq_size[scan_i[WI_W-1:0]] > best) &&
                  (int'(scan_i) < int'(n_eff));
      if (stealable) begin
        best  <= dq_size[scan_i[WI_W-1:0]];
        sel   <= scan_i[WI_W-1:0];
        found <= 1'b1;
      end
      scan_i <= scan_i + 1'b1;
      opw_q  <= w_idx;
      case (kind_q)
        KIND_EXT: op_q <= OP_PUSH_GLOBAL;
        KIND_LOCAL: begin
          if (w_ok && int'(dq_size[w_idx]) < LOCAL_DEPTH - 1) op_q <= OP_PUSH_LOCAL;
          else op_q <= OP_PUSH_GLOBAL;
        end
        KIND_FETCH: begin
          if (!w_ok) op_q <= OP_NOTHING;
          else if (dq_size[w_idx] != '0) op_q <= OP_POP_OWN;
          else if (sh_size != '0) op_q <= OP_POP_GLOBAL;
          else if (stealable || found) begin
            op_q  <= OP_STEAL;
            opw_q <= stealable ? scan_i[WI_W-1:0] : sel;
          end else op_q <= OP_NOTHING;
        end
        default: op_q <= OP_NOTHING;
      endcase
    end
  end

  // scan index never passes the worker range while scanning
  assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> int'(scan_i) < WORKERS) else $error("scan overran");
  // a steal never names the requester
  assert property (@(posedge clk) disable iff (rst)
    op_valid && op_code == OP_STEAL |-> op_worker != w_idx) else $error("self steal");
  // no new beat while an op is held
  assert property (@(posedge clk) disable iff (rst)
    op_valid |-> !req.ready) else $error("front overlap");
endmodule

// ===== src/wstq_back.sv =====
module wstq_back
  import wstq_pkg::*;
#(
  parameter int WORKERS      = WORKERS_DEF,
  parameter int LOCAL_DEPTH  = LOCAL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = GLOBAL_DEPTH_DEF,
  parameter int TASK_BITS    = TASK_BITS_DEF,
  localparam int WI_W = $clog2(WORKERS),
  localparam int LA_W = $clog2(LOCAL_DEPTH),
  localparam int LP_W = LA_W + 1,
  localparam int GA_W = $clog2(GLOBAL_DEPTH),
  localparam int GP_W = GA_W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_ready,
  input  op_t                  op_code,
  input  logic [WI_W-1:0]      op_worker,
  input  logic [TASK_BITS-1:0] op_task,
  output logic [LP_W-1:0]      dq_size [WORKERS],
  output logic [GP_W-1:0]      sh_size,
  output logic                 busy,
  wstq_rsp_if.source           rsp
);
  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_READ = 3'b010,
    B_OUT  = 3'b100
  } bstate_t;

  bstate_t state, state_next;
  logic [LP_W-1:0] dhead [WORKERS];
  logic [LP_W-1:0] dtail [WORKERS];
  logic [GP_W-1:0] shead, stail;
  logic [COUNT_W-1:0] count;
  op_t             op_q;
  logic [WI_W-1:0] wk_q;
  logic [STATUS_W-1:0] st_q;
  logic            rd_q;
  logic [TASK_BITS-1:0] rdat_q;

  logic                  dwe, swe;
  logic [WI_W+LA_W-1:0]  dwa, dra;
  logic [GA_W-1:0]       swa, sra;
  logic [TASK_BITS-1:0]  drd, srd;
  logic [LP_W-1:0]       hd, hdec, hinc, tinc;
  logic [GP_W-1:0]       shinc, stinc;

  function automatic logic [LP_W-1:0] lsize(logic [LP_W-1:0] h, logic [LP_W-1:0] t);
    lsize = (h >= t) ? h - t : LP_W'(h + LP_W'(2*LOCAL_DEPTH) - t);
  endfunction

  // occupancy for the front part
  always_comb begin
    for (int i = 0; i < WORKERS; i++) dq_size[i] = lsize(dhead[i], dtail[i]);
    sh_size = (shead >= stail) ? shead - stail : GP_W'(shead + GP_W'(2*GLOBAL_DEPTH) - stail);
  end

  assign hd    = dhead[op_worker];
  assign hdec  = (hd == '0) ? LP_W'(2*LOCAL_DEPTH-1) : hd - 1'b1;
  assign hinc  = (int'(hd) + 1 >= 2*LOCAL_DEPTH) ? '0 : hd + 1'b1;
  assign tinc  = (int'(dtail[op_worker]) + 1 >= 2*LOCAL_DEPTH) ? '0 : dtail[op_worker] + 1'b1;
  assign shinc = (int'(shead) + 1 >= 2*GLOBAL_DEPTH) ? '0 : shead + 1'b1;
  assign stinc = (int'(stail) + 1 >= 2*GLOBAL_DEPTH) ? '0 : stail + 1'b1;

  assign op_ready = (state == B_IDLE);
  assign busy     = (state != B_IDLE);
  assign rsp.valid = (state == B_OUT);
  assign rsp.status = st_q;
  assign rsp.task_out = rd_q ? TASK_W'(rdat_q) : '0;
  assign rsp.victim = (op_q == OP_STEAL && rd_q) ? WORKER_W'(wk_q) : '0;
  assign rsp.queued_total = count;

  // memory addresses
  assign dwe = op_valid && op_ready && op_code == OP_PUSH_LOCAL;
  assign swe = op_valid && op_ready && op_code == OP_PUSH_GLOBAL &&
               int'(sh_size) < GLOBAL_DEPTH - 1;
  assign dwa = {op_worker, hd[LA_W-1:0]};
  assign swa = shead[GA_W-1:0];
  assign sra = stail[GA_W-1:0];
  assign dra = (op_code == OP_STEAL) ? {op_worker, dtail[op_worker][LA_W-1:0]}
                                     : {op_worker, hdec[LA_W-1:0]};

  wstq_ram #(.WIDTH(TASK_BITS), .DEPTH(WORKERS*LOCAL_DEPTH)) u_dq (
    .clk(clk), .we(dwe), .waddr(dwa), .wdata(op_task), .raddr(dra), .rdata(drd));
  wstq_ram #(.WIDTH(TASK_BITS), .DEPTH(GLOBAL_DEPTH)) u_sh (
    .clk(clk), .we(swe), .waddr(swa), .wdata(op_task), .raddr(sra), .rdata(srd));

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (op_valid) state_next = B_READ;
      B_READ: state_next = B_OUT;
      B_OUT:  if (rsp.ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // pointer and count updates on each op beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      shead <= '0;
      stail <= '0;
      count <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        dhead[i] <= '0;
        dtail[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (op_valid && op_ready) begin
        case (op_code)
          OP_PUSH_LOCAL: begin
            dhead[op_worker] <= hinc;
            count <= count + 1'b1;
          end
          OP_PUSH_GLOBAL: if (swe) begin
            shead <= shinc;
            count <= count + 1'b1;
          end
          OP_POP_OWN: begin
            dhead[op_worker] <= hdec;
            count <= count - 1'b1;
          end
          OP_POP_GLOBAL: begin
            stail <= stinc;
            count <= count - 1'b1;
          end
          OP_STEAL: begin
            dtail[op_worker] <= tinc;
            count <= count - 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      op_q <= op_code;
      wk_q <= op_worker;
      rd_q <= (op_code == OP_POP_OWN || op_code == OP_POP_GLOBAL || op_code == OP_STEAL);
      case (op_code)
        OP_PUSH_LOCAL:  st_q <= ST_LOCAL;
        OP_PUSH_GLOBAL: st_q <= swe ? ST_GLOBAL : ST_REJECT;
        OP_POP_OWN:     st_q <= ST_OWN;
        OP_POP_GLOBAL:  st_q <= ST_SHARED;
        OP_STEAL:       st_q <= ST_STOLEN;
        default:        st_q <= ST_NONE;
      endcase
    end
    // hold the read word, the ram output moves on once the pointers do
    if (state == B_READ) begin
      rdat_q <= (op_q == OP_POP_GLOBAL) ? srd : drd;
    end
  end

  // shared ring never exceeds its capacity
  assert property (@(posedge clk) disable iff (rst)
    int'(sh_size) < GLOBAL_DEPTH) else $error("shared ring overfull");
  // an own pop or steal beat always drops the count by one
  assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready && (op_code == OP_POP_OWN || op_code == OP_STEAL)
    |=> count == $past(count) - 1'b1) else $error("count slip");
  // the result beat follows the op beat after the read cycle
  assert property (@(posedge clk) disable iff (rst)
    op_valid && op_ready |=> ##1 rsp.valid) else $error("late result");
endmodule

// ===== src/work_stealing_task_queues.sv =====
// path: request beat, victim scan, op beat, ram read, result beat
// throughput: one request at a time; a fetch that falls through to stealing scans
//   one worker deque a cycle
// reset: synchronous rst clears all ring pointers, the task count and the worker
//   count (back to 8); the task stores are not cleared
module work_stealing_task_queues
  import wstq_pkg::*;
#(
  parameter int WORKERS      = WORKERS_DEF,
  parameter int LOCAL_DEPTH  = LOCAL_DEPTH_DEF,
  parameter int GLOBAL_DEPTH = GLOBAL_DEPTH_DEF,
  parameter int TASK_BITS    = TASK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [ACTIVE_W-1:0] cfg_data,
  wstq_req_if.sink            req,
  wstq_rsp_if.source          rsp
);
  localparam int WI_W = $clog2(WORKERS);
  localparam int LP_W = $clog2(LOCAL_DEPTH) + 1;
  localparam int GP_W = $clog2(GLOBAL_DEPTH) + 1;

  logic [ACTIVE_W-1:0]  active_workers;
  logic                 op_valid, op_ready, busy;
  op_t                  op_code;
  logic [WI_W-1:0]      op_worker;
  logic [TASK_BITS-1:0] op_task;
  logic [LP_W-1:0]      dq_size [WORKERS];
  logic [GP_W-1:0]      sh_size;

  // worker count register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_workers <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_workers <= cfg_data;
    end
  end

  wstq_front #(.WORKERS(WORKERS), .LOCAL_DEPTH(LOCAL_DEPTH),
    .GLOBAL_DEPTH(GLOBAL_DEPTH), .TASK_BITS(TASK_BITS)) u_front (
    .clk(clk), .rst(rst), .active_workers(active_workers), .req(req),
    .op_valid(op_valid), .op_ready(op_ready), .op_code(op_code),
    .op_worker(op_worker), .op_task(op_task), .dq_size(dq_size),
    .sh_size(sh_size), .busy(busy));

  wstq_back #(.WORKERS(WORKERS), .LOCAL_DEPTH(LOCAL_DEPTH),
    .GLOBAL_DEPTH(GLOBAL_DEPTH), .TASK_BITS(TASK_BITS)) u_back (
    .clk(clk), .rst(rst), .op_valid(op_valid), .op_ready(op_ready),
    .op_code(op_code), .op_worker(op_worker), .op_task(op_task),
    .dq_size(dq_size), .sh_size(sh_size), .busy(busy), .rsp(rsp));
endmodule
